/* design/lowest_free_block_allocator_assert.svh */
// Assertion macros for the block allocator.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef LOWEST_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_BLOCK_ALLOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lfba_pkg.sv */
`default_nettype none
package lfba_pkg;

	localparam int NUM_BLOCKS    = 1024;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
	localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
	localparam int BLK_W         = 10;
	localparam int CNT_W         = 11;

	localparam logic [CNT_W-1:0] BLOCK_LIMIT = CNT_W'(NUM_BLOCKS);

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef logic [MAP_WORD_BITS-1:0] map_word_t;
	typedef logic [MAP_WORDS-1:0]     summary_t;
	typedef logic [WORD_IDX_W-1:0]    word_idx_t;
	typedef logic [BIT_IDX_W-1:0]     bit_idx_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_SPACE    = 2'd1,
		ST_BAD_RELEASE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WRITE
	} fsm_t;

	typedef struct packed {
		logic      rd_en;
		logic      wr_en;
		word_idx_t addr;
		map_word_t wdata;
	} map_req_t;

	function automatic word_idx_t first_word(input summary_t s);
		word_idx_t idx;
		idx = '0;
		for (int i = MAP_WORDS - 1; i >= 0; i--) begin
			if (s[i]) begin
				idx = WORD_IDX_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic bit_idx_t first_bit(input map_word_t w);
		bit_idx_t idx;
		idx = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = BIT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

/* design/lowest_free_block_allocator.sv */
// Lowest-first free block allocator.
// Request channel: in_valid/in_stall carry req_type (0 allocate, 1 release)
// and block_in. A beat is taken when in_valid is high and in_stall is low.
// Result channel: out_valid/out_stall carry status, block_out,
// blocks_allocated and free_count, one result beat per request beat.
// Config channel: cfg_valid/cfg_ready writes forget_free_space from
// cfg_data; cfg_ready is always high. Write it only while idle.
// Each request passes through three steps: accept, one read of the bitmap
// RAM, and one write-back that also loads the result register. A new request
// is taken only in idle, once the last write-back is done. The lowest free
// word comes from a one-bit-per-word summary register, the lowest free bit
// from the word read out of the single-port RAM.
// If the receiver stalls, the finished result is held and the next request
// is still accepted and read; its write-back waits until the result register
// is free, with in_stall high meanwhile.
// Reset clears the summary, counters, mode bit and valid flags at once; RAM
// words whose summary bit is clear read as empty, so no clearing pass runs.
`default_nettype none
module lowest_free_block_allocator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_stall,
	input  wire logic                        req_type,
	input  wire logic [lfba_pkg::BLK_W-1:0]  block_in,
	output      logic                        out_valid,
	input  wire logic                        out_stall,
	output      logic [1:0]                  status,
	output      logic [lfba_pkg::BLK_W-1:0]  block_out,
	output      logic [lfba_pkg::CNT_W-1:0]  blocks_allocated,
	output      logic [lfba_pkg::CNT_W-1:0]  free_count,
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic                        cfg_data
);
	import lfba_pkg::*;

	`include "lowest_free_block_allocator_assert.svh"

	fsm_t                 state_q, state_d;
	logic                 forget_q;
	logic                 req_q;
	logic [BLK_W-1:0]     blk_q;
	word_idx_t            widx_q;
	logic                 hit_q;
	summary_t             summary_q, summary_d;
	logic [CNT_W-1:0]     high_water_q, high_water_d;
	logic [CNT_W-1:0]     free_total_q, free_total_d;

	logic                 out_valid_q;
	status_t              status_q, status_d;
	logic [BLK_W-1:0]     block_out_q, block_out_d;

	map_req_t             ram_req;
	map_word_t            rdata;
	map_word_t            word;
	map_word_t            mask;
	bit_idx_t             bsel;
	logic                 accept;
	logic                 wr_go;

	lfba_map_ram u_map (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign wr_go     = (state_q == S_WRITE) && (!out_valid_q || !out_stall);
	assign word      = summary_q[widx_q] ? rdata : '0;
	assign bsel      = (req_q == REQ_ALLOC) ? first_bit(word) : blk_q[BIT_IDX_W-1:0];
	assign mask      = map_word_t'(1) << bsel;

	always_comb begin
		state_d       = state_q;
		summary_d     = summary_q;
		high_water_d  = high_water_q;
		free_total_d  = free_total_q;
		status_d      = ST_OK;
		block_out_d   = '0;
		ram_req.rd_en = 1'b0;
		ram_req.wr_en = 1'b0;
		ram_req.addr  = widx_q;
		ram_req.wdata = word;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				ram_req.rd_en = 1'b1;
				ram_req.addr  = (req_q == REQ_ALLOC) ? first_word(summary_q)
				                                     : blk_q[BLK_W-1:BIT_IDX_W];
				state_d       = S_WRITE;
			end
			S_WRITE: begin
				if (req_q == REQ_ALLOC) begin
					if (hit_q) begin
						ram_req.wdata = word & ~mask;
						block_out_d   = {widx_q, bsel};
						free_total_d  = free_total_q - CNT_W'(1);
						summary_d[widx_q] = |(word & ~mask);
					end else if (high_water_q < BLOCK_LIMIT) begin
						block_out_d  = high_water_q[BLK_W-1:0];
						high_water_d = high_water_q + CNT_W'(1);
					end else begin
						status_d = ST_NO_SPACE;
					end
				end else begin
					ram_req.wdata = word | mask;
					if ({1'b0, blk_q} >= high_water_q) begin
						status_d = ST_BAD_RELEASE;
					end else if (!forget_q && !word[bsel]) begin
						ram_req.wr_en = wr_go;
						free_total_d  = free_total_q + CNT_W'(1);
						summary_d[widx_q] = 1'b1;
					end
				end
				if (req_q == REQ_ALLOC && hit_q) begin
					ram_req.wr_en = wr_go;
				end
				if (wr_go) begin
					state_d = S_IDLE;
				end else begin
					summary_d    = summary_q;
					high_water_d = high_water_q;
					free_total_d = free_total_q;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			forget_q     <= 1'b0;
			summary_q    <= '0;
			high_water_q <= '0;
			free_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			summary_q    <= summary_d;
			high_water_q <= high_water_d;
			free_total_q <= free_total_d;
			if (cfg_valid && cfg_ready) begin
				forget_q <= cfg_data;
			end
			if (wr_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			blk_q <= block_in;
		end
		if (state_q == S_READ) begin
			widx_q <= ram_req.addr;
			hit_q  <= |summary_q;
		end
		if (wr_go) begin
			status_q    <= status_d;
			block_out_q <= block_out_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign block_out        = block_out_q;
	assign blocks_allocated = high_water_q;
	assign free_count       = free_total_q;

	`LFBA_ASSERT_NOW(a_summary_matches_count, 1'b1, ((free_total_q != '0) == (|summary_q)), "summary and free count disagree")
	`LFBA_ASSERT_NOW(a_free_below_high_water, 1'b1, (free_total_q <= high_water_q), "free count above high-water mark")
	`LFBA_ASSERT_NOW(a_no_space_at_limit, (out_valid_q && status_q == ST_NO_SPACE), (high_water_q == BLOCK_LIMIT && summary_q == '0), "no-space result while space remains")
	`LFBA_ASSERT_NEXT(a_accept_starts_read, accept, (state_q == S_READ), "accepted beat did not start a read")

endmodule
`default_nettype wire

/* design/lfba_map_ram.sv */
`default_nettype none
module lfba_map_ram (
	input  wire logic               clk,
	input  wire lfba_pkg::map_req_t req,
	output      lfba_pkg::map_word_t rdata
);
	import lfba_pkg::*;

	map_word_t mem [MAP_WORDS];
	map_word_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
	import lfba_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		status_t          st;
		logic [BLK_W-1:0] blk;
		logic [CNT_W-1:0] hw;
		logic [CNT_W-1:0] fc;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = REQ_ALLOC;
	logic [BLK_W-1:0] block_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [BLK_W-1:0] block_out;
	logic [CNT_W-1:0] blocks_allocated;
	logic [CNT_W-1:0] free_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	grant_t pending_grants[$];
	logic [NUM_BLOCKS-1:0] spare_set = '0;
	logic [CNT_W-1:0] issued_total = '0;
	logic [CNT_W-1:0] spare_total = '0;
	logic forget_mode = 1'b0;

	int errors = 0;
	int cycles = 0;
	int hold_req = 0;
	int stall_left = 0;
	bit in_idle_on = 1'b0;
	bit out_idle_on = 1'b0;

	lowest_free_block_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.block_in(block_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.block_out(block_out),
		.blocks_allocated(blocks_allocated),
		.free_count(free_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void predict_grant(input logic rt, input logic [BLK_W-1:0] bi);
		grant_t g;
		int lowest;
		g.st = ST_OK;
		g.blk = '0;
		lowest = -1;
		if (rt == REQ_ALLOC) begin
			for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
				if (spare_set[i]) lowest = i;
			end
			if (lowest >= 0) begin
				spare_set[lowest] = 1'b0;
				spare_total--;
				g.blk = BLK_W'(lowest);
			end else if (issued_total < BLOCK_LIMIT) begin
				g.blk = issued_total[BLK_W-1:0];
				issued_total++;
			end else begin
				g.st = ST_NO_SPACE;
			end
		end else if ({1'b0, bi} >= issued_total) begin
			g.st = ST_BAD_RELEASE;
		end else if (!forget_mode && !spare_set[bi]) begin
			spare_set[bi] = 1'b1;
			spare_total++;
		end
		g.hw = issued_total;
		g.fc = spare_total;
		pending_grants.push_back(g);
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual status %0d block %0d",
					$time, status, block_out);
				errors++;
			end else begin
				want = pending_grants.pop_front();
				check_field("status", int'(want.st), int'(status));
				check_field("block_out", int'(want.blk), int'(block_out));
				check_field("blocks_allocated", int'(want.hw), int'(blocks_allocated));
				check_field("free_count", int'(want.fc), int'(free_count));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
			out_stall = 1'b1;
			stall_left = pick_gap();
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic send_beat(input logic rt, input logic [BLK_W-1:0] bi);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		req_type = rt;
		block_in = bi;
		do @(posedge clk); while (in_stall);
		predict_grant(rt, bi);
		gap = in_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			req_type = 1'($urandom);
			block_in = BLK_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	task automatic set_forget(input logic v);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		forget_mode = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_mix(input int n, input int alloc_pct);
		logic [BLK_W-1:0] b;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < alloc_pct) begin
				send_beat(REQ_ALLOC, BLK_W'($urandom));
			end else begin
				if ($urandom_range(0, 99) < 75 && issued_total > 0)
					b = BLK_W'($urandom_range(0, int'(issued_total) - 1));
				else
					b = BLK_W'($urandom);
				send_beat(REQ_RELEASE, b);
			end
		end
	endtask

	task automatic test_directed();
		send_beat(REQ_RELEASE, 10'd0);
		send_beat(REQ_RELEASE, 10'd1023);
		send_beat(REQ_ALLOC, 10'd1023);
		send_beat(REQ_ALLOC, 10'd0);
		send_beat(REQ_ALLOC, 10'd1023);
		send_beat(REQ_ALLOC, 10'd0);
		send_beat(REQ_RELEASE, 10'd3);
		send_beat(REQ_RELEASE, 10'd1);
		send_beat(REQ_RELEASE, 10'd1);
		send_beat(REQ_RELEASE, 10'd4);
		send_beat(REQ_ALLOC, 10'd0);
		send_beat(REQ_ALLOC, 10'd0);
		send_beat(REQ_ALLOC, 10'd0);
		set_forget(1'b1);
		send_beat(REQ_RELEASE, 10'd2);
		send_beat(REQ_RELEASE, 10'd9);
		send_beat(REQ_ALLOC, 10'd0);
		set_forget(1'b0);
		send_beat(REQ_RELEASE, 10'd0);
		send_beat(REQ_ALLOC, 10'd0);
		wait_drained();
	endtask

	task automatic test_random_mix();
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		run_mix(80, 60);
		set_forget(1'b1);
		run_mix(50, 50);
		set_forget(1'b0);
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		run_mix(50, 55);
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		run_mix(80, 45);
		wait_drained();
	endtask

	task automatic test_backpressure();
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		hold_req = 120;
		run_mix(30, 60);
		wait_drained();
		in_idle_on = 1'b1;
		out_idle_on = 1'b1;
		run_mix(20, 50);
		wait_drained();
	endtask

	task automatic test_fill_to_capacity();
		in_idle_on = 1'b0;
		out_idle_on = 1'b0;
		while (!(issued_total == BLOCK_LIMIT && spare_total == 0))
			send_beat(REQ_ALLOC, BLK_W'($urandom));
		send_beat(REQ_ALLOC, 10'd0);
		send_beat(REQ_ALLOC, 10'd1023);
		send_beat(REQ_RELEASE, 10'd1023);
		send_beat(REQ_RELEASE, 10'd0);
		send_beat(REQ_RELEASE, 10'd511);
		send_beat(REQ_RELEASE, 10'd511);
		repeat (4) send_beat(REQ_ALLOC, 10'd0);
		set_forget(1'b1);
		send_beat(REQ_RELEASE, 10'd700);
		send_beat(REQ_ALLOC, 10'd0);
		set_forget(1'b0);
		send_beat(REQ_RELEASE, 10'd700);
		send_beat(REQ_ALLOC, 10'd0);
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_mix();
		test_backpressure();
		test_fill_to_capacity();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_grants.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
